@@ sv/vts_pkg.sv @@
package vts_pkg;

  // default grid limit per axis
  localparam int GRID_MAX_DEF = 1024;

  // field widths
  localparam int SIZE_W     = 31;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int PT_W       = 35;
  localparam int DIV_BITS   = 31;
  localparam int REM_W      = 33;

  // saturated distance
  localparam logic [DIV_BITS-1:0] T_SAT = '1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOXEL_SIZE_X = 3'd0,
    REG_VOXEL_SIZE_Y = 3'd1,
    REG_VOXEL_SIZE_Z = 3'd2,
    REG_GRID_COUNT_X = 3'd3,
    REG_GRID_COUNT_Y = 3'd4,
    REG_GRID_COUNT_Z = 3'd5
  } cfg_reg_t;

  // axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_code_t;

  // one ray
  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] entry_t;
  } ray_in_t;

  // one per-axis result
  typedef struct packed {
    logic [1:0]  axis;
    logic [9:0]  voxel_index;
    logic [30:0] next_cross_t;
    logic [30:0] cross_spacing_t;
    logic [21:0] buffer_step;
    logic [10:0] crossings_left;
    logic [29:0] start_offset;
    logic        last;
  } axis_out_t;

  // entry point and direction facts of one axis
  typedef struct packed {
    logic signed [PT_W-1:0] pt;
    logic                   dpos;
    logic                   dneg;
    logic [31:0]            d;
  } pside_t;

  // per-axis work handed to the quotient pipeline
  typedef struct packed {
    logic [9:0]       idx;
    logic [10:0]      left;
    logic [21:0]      step;
    logic             dz;
    logic             le0;
    logic             nsat;
    logic             ssat;
    logic [REM_W-1:0] n_next;
    logic [REM_W-1:0] n_sp;
    logic [31:0]      d;
  } axis_work_t;

  // all three axes of one ray
  typedef struct packed {
    axis_work_t [2:0] ax;
    logic [29:0]      offs;
  } ray_work_t;

  // sideband that travels through the quotient pipeline
  typedef struct packed {
    logic [1:0]  axis;
    logic [9:0]  idx;
    logic [10:0] left;
    logic [21:0] step;
    logic [29:0] offs;
    logic        last;
    logic        dz;
    logic        le0;
    logic        nsat;
    logic        ssat;
    logic [31:0] d;
  } bside_t;

endpackage

@@ sv/vts_ray.sv @@
module vts_ray #(
  parameter int GRID_MAX = vts_pkg::GRID_MAX_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  vts_pkg::ray_in_t                        in_data,
  input  logic [2:0][vts_pkg::SIZE_W-1:0]         voxel_size,
  input  logic [2:0][vts_pkg::COUNT_W-1:0]        grid_count,
  output logic                                    ray_valid,
  output vts_pkg::ray_work_t                      ray,
  input  logic                                    ray_take
);
  import vts_pkg::*;

  localparam int IB   = $clog2(GRID_MAX);
  localparam int CW   = $clog2(GRID_MAX + 1);
  localparam int IRW  = (IB + SIZE_W > PT_W) ? IB + SIZE_W : PT_W;
  localparam int MW   = CW + SIZE_W;
  localparam int NUMW = CW + SIZE_W + 4;
  localparam int AW   = 2 * CW + 1;
  localparam int OW   = 3 * CW + 1;

  logic adv;

  // effective sizes and counts
  logic [SIZE_W-1:0] vsz   [3];
  logic [CW-1:0]     cnt   [3];
  logic [CW-1:0]     cntm1 [3];

  // stage 1: input
  logic               v1;
  logic signed [31:0] dir1 [3];
  logic signed [31:0] org1 [3];
  logic signed [31:0] t1;

  // stage 2: product
  logic               v2;
  logic signed [63:0] prod2 [3];
  logic signed [31:0] org2  [3];
  logic               dpos2 [3];
  logic               dneg2 [3];
  logic [31:0]        d2    [3];

  // stage 3: entry point
  logic                   v3;
  logic signed [PT_W-1:0] pt_c [3];
  logic signed [PT_W:0]   pp_c [3];
  pside_t                 ps3  [3];
  logic signed [PT_W:0]   pp3  [3];

  // index division stages
  logic           iv   [IB+1];
  logic [IRW-1:0] irem [IB+1][3];
  logic [IB-1:0]  iq   [IB+1][3];
  logic           ineg [IB+1][3];
  logic           iovf [IB+1][3];
  pside_t         ps   [IB+1][3];

  // clamp stage
  logic          v5;
  logic [CW-1:0] idx5 [3];
  pside_t        ps5  [3];

  // products stage
  logic          v6;
  logic [MW-1:0] m6   [3];
  logic [AW-1:0] a6;
  logic [AW-1:0] nxny6;
  logic [CW-1:0] idx6 [3];
  pside_t        ps6  [3];

  // numerators, offset, step stage
  logic                   v7;
  logic signed [NUMW-1:0] num7  [3];
  logic [29:0]            offs7;
  logic [10:0]            left7 [3];
  logic [21:0]            step7 [3];
  logic [9:0]             idx7  [3];
  pside_t                 ps7   [3];

  assign adv      = !ray_valid || ray_take;
  assign in_stall = !adv;

  // zero size reads as one, count clamped to 1..GRID_MAX
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsz[k] = (voxel_size[k] == '0) ? SIZE_W'(1) : voxel_size[k];
      if (grid_count[k] == '0) begin
        cnt[k] = CW'(1);
      end else if (int'(grid_count[k]) > GRID_MAX) begin
        cnt[k] = CW'(GRID_MAX);
      end else begin
        cnt[k] = CW'(grid_count[k]);
      end
      cntm1[k] = cnt[k] - CW'(1);
    end
  end

  // entry point, floored shift of the product; point less one for a negative direction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_c[k] = PT_W'(prod2[k] >>> 30) + PT_W'(org2[k]);
      pp_c[k] = (PT_W + 1)'(pt_c[k]) - (dneg2[k] ? (PT_W + 1)'(1) : (PT_W + 1)'(0));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      ray_valid <= 1'b0;
      for (int j = 0; j <= IB; j++) begin
        iv[j] <= 1'b0;
      end
    end else if (adv) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      iv[0] <= v3;
      for (int j = 0; j < IB; j++) begin
        iv[j+1] <= iv[j];
      end
      v5        <= iv[IB];
      v6        <= v5;
      v7        <= v6;
      ray_valid <= v7;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      dir1[0]  <= in_data.dir_x;
      dir1[1]  <= in_data.dir_y;
      dir1[2]  <= in_data.dir_z;
      org1[0]  <= in_data.origin_x;
      org1[1]  <= in_data.origin_y;
      org1[2]  <= in_data.origin_z;
      t1       <= in_data.entry_t;

      for (int k = 0; k < 3; k++) begin
        // product and direction magnitude
        prod2[k] <= 64'(dir1[k]) * 64'(t1);
        org2[k]  <= org1[k];
        dpos2[k] <= dir1[k] > 0;
        dneg2[k] <= dir1[k] < 0;
        d2[k]    <= dir1[k][31] ? 32'(-dir1[k]) : 32'(dir1[k]);

        // entry point
        ps3[k].pt   <= pt_c[k];
        ps3[k].dpos <= dpos2[k];
        ps3[k].dneg <= dneg2[k];
        ps3[k].d    <= d2[k];
        pp3[k]      <= pp_c[k];

        // index beyond the widest grid saturates
        ineg[0][k] <= pp3[k] < 0;
        iovf[0][k] <= IRW'(pp3[k][PT_W-1:0]) >= (IRW'(vsz[k]) << IB);
        irem[0][k] <= IRW'(pp3[k][PT_W-1:0]);
        iq[0][k]   <= '0;
        ps[0][k]   <= ps3[k];

        // one quotient bit per stage
        for (int j = 0; j < IB; j++) begin
          ineg[j+1][k] <= ineg[j][k];
          iovf[j+1][k] <= iovf[j][k];
          ps[j+1][k]   <= ps[j][k];
          if (irem[j][k] >= (IRW'(vsz[k]) << (IB - 1 - j))) begin
            irem[j+1][k] <= irem[j][k] - (IRW'(vsz[k]) << (IB - 1 - j));
            iq[j+1][k]   <= iq[j][k] | (IB'(1) << (IB - 1 - j));
          end else begin
            irem[j+1][k] <= irem[j][k];
            iq[j+1][k]   <= iq[j][k];
          end
        end

        // clamp to the grid
        if (ineg[IB][k]) begin
          idx5[k] <= '0;
        end else if (iovf[IB][k] || (CW'(iq[IB][k]) > cntm1[k])) begin
          idx5[k] <= cntm1[k];
        end else begin
          idx5[k] <= CW'(iq[IB][k]);
        end
        ps5[k] <= ps[IB][k];

        // boundary position
        m6[k]   <= MW'(idx5[k]) * MW'(vsz[k]);
        idx6[k] <= idx5[k];
        ps6[k]  <= ps5[k];

        // distance numerator and crossings left
        if (ps6[k].dpos) begin
          num7[k]  <= NUMW'(m6[k]) + NUMW'(vsz[k]) - NUMW'(ps6[k].pt);
          left7[k] <= 11'((CW + 1)'(cnt[k]) - (CW + 1)'(idx6[k]));
        end else if (ps6[k].dneg) begin
          num7[k]  <= NUMW'(ps6[k].pt) - NUMW'(m6[k]);
          left7[k] <= 11'((CW + 1)'(idx6[k]) + (CW + 1)'(1));
        end else begin
          num7[k]  <= '0;
          left7[k] <= 11'(1);
        end
        idx7[k] <= 10'(idx6[k]);
        ps7[k]  <= ps6[k];

        // hand-off register
        ray.ax[k].idx    <= idx7[k];
        ray.ax[k].left   <= left7[k];
        ray.ax[k].step   <= step7[k];
        ray.ax[k].dz     <= !ps7[k].dpos && !ps7[k].dneg;
        ray.ax[k].le0    <= num7[k] <= 0;
        ray.ax[k].nsat   <= num7[k] >= $signed(NUMW'({ps7[k].d, 1'b0}));
        ray.ax[k].ssat   <= REM_W'(vsz[k]) >= {ps7[k].d, 1'b0};
        ray.ax[k].n_next <= REM_W'(num7[k]);
        ray.ax[k].n_sp   <= REM_W'(vsz[k]);
        ray.ax[k].d      <= ps7[k].d;
      end

      // partial linear offset and z stride
      a6    <= AW'(idx5[1]) + AW'(cnt[1]) * AW'(idx5[2]);
      nxny6 <= AW'(cnt[0]) * AW'(cnt[1]);

      // linear offset
      offs7 <= 30'(OW'(idx6[0]) + OW'(cnt[0]) * OW'(a6));

      // signed strides per axis
      step7[0] <= ps6[0].dpos ? 22'(1)
                : ps6[0].dneg ? 22'(-AW'(1)) : '0;
      step7[1] <= ps6[1].dpos ? 22'(AW'(cnt[0]))
                : ps6[1].dneg ? 22'(-AW'(cnt[0])) : '0;
      step7[2] <= ps6[2].dpos ? 22'(nxny6)
                : ps6[2].dneg ? 22'(-nxny6) : '0;

      ray.offs <= offs7;
    end
  end

endmodule

@@ sv/vts_axis.sv @@
module vts_axis (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ray_valid,
  input  vts_pkg::ray_work_t   ray,
  output logic                 ray_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vts_pkg::axis_out_t   out_data
);
  import vts_pkg::*;

  logic       adv;
  axis_code_t sel;
  axis_work_t cur;

  // quotient pipeline stages, index 0 is the load stage
  logic                bv [DIV_BITS+1];
  bside_t              bs [DIV_BITS+1];
  logic [REM_W-1:0]    rn [DIV_BITS+1];
  logic [REM_W-1:0]    rs [DIV_BITS+1];
  logic [DIV_BITS-1:0] qn [DIV_BITS+1];
  logic [DIV_BITS-1:0] qs [DIV_BITS+1];

  assign adv      = !out_valid || !out_stall;
  assign cur      = ray.ax[sel];
  assign ray_take = adv && ray_valid && (sel == AXIS_Z);

  // axis select, x then y then z
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= AXIS_X;
    end else if (adv && ray_valid) begin
      sel <= (sel == AXIS_Z) ? AXIS_X : axis_code_t'(sel + 2'd1);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i <= DIV_BITS; i++) begin
        bv[i] <= 1'b0;
      end
    end else if (adv) begin
      bv[0] <= ray_valid;
      for (int i = 0; i < DIV_BITS; i++) begin
        bv[i+1] <= bv[i];
      end
      out_valid <= bv[DIV_BITS];
    end
  end

  // load, restoring quotient steps, result register
  always_ff @(posedge clk) begin : p_div
    logic [REM_W-1:0] tn;
    logic [REM_W-1:0] ts;
    if (adv) begin
      bs[0].axis <= sel;
      bs[0].idx  <= cur.idx;
      bs[0].left <= cur.left;
      bs[0].step <= cur.step;
      bs[0].offs <= ray.offs;
      bs[0].last <= sel == AXIS_Z;
      bs[0].dz   <= cur.dz;
      bs[0].le0  <= cur.le0;
      bs[0].nsat <= cur.nsat;
      bs[0].ssat <= cur.ssat;
      bs[0].d    <= cur.d;
      rn[0]      <= cur.n_next;
      rs[0]      <= cur.n_sp;
      qn[0]      <= '0;
      qs[0]      <= '0;

      // first step compares the numerator itself, later ones the doubled remainder
      for (int i = 0; i < DIV_BITS; i++) begin
        tn = (i == 0) ? rn[i] : {rn[i][REM_W-2:0], 1'b0};
        ts = (i == 0) ? rs[i] : {rs[i][REM_W-2:0], 1'b0};
        if (tn >= REM_W'(bs[i].d)) begin
          rn[i+1] <= tn - REM_W'(bs[i].d);
          qn[i+1] <= {qn[i][DIV_BITS-2:0], 1'b1};
        end else begin
          rn[i+1] <= tn;
          qn[i+1] <= {qn[i][DIV_BITS-2:0], 1'b0};
        end
        if (ts >= REM_W'(bs[i].d)) begin
          rs[i+1] <= ts - REM_W'(bs[i].d);
          qs[i+1] <= {qs[i][DIV_BITS-2:0], 1'b1};
        end else begin
          rs[i+1] <= ts;
          qs[i+1] <= {qs[i][DIV_BITS-2:0], 1'b0};
        end
        bs[i+1] <= bs[i];
      end

      // saturation and zero-direction cases
      out_data.axis        <= bs[DIV_BITS].axis;
      out_data.voxel_index <= bs[DIV_BITS].idx;
      if (bs[DIV_BITS].dz || (!bs[DIV_BITS].le0 && bs[DIV_BITS].nsat)) begin
        out_data.next_cross_t <= T_SAT;
      end else if (bs[DIV_BITS].le0) begin
        out_data.next_cross_t <= '0;
      end else begin
        out_data.next_cross_t <= qn[DIV_BITS];
      end
      out_data.cross_spacing_t <= (bs[DIV_BITS].dz || bs[DIV_BITS].ssat) ?
                                  T_SAT : qs[DIV_BITS];
      out_data.buffer_step     <= bs[DIV_BITS].step;
      out_data.crossings_left  <= bs[DIV_BITS].left;
      out_data.start_offset    <= bs[DIV_BITS].offs;
      out_data.last            <= bs[DIV_BITS].last;
    end
  end

endmodule

@@ sv/voxel_traversal_setup.sv @@
// Voxel traversal setup: takes one ray (direction, start point, entry distance) per
// transfer and returns three results, x then y then z, each with the entry voxel index,
// the distance to the next boundary, the distance between boundaries, the signed
// buffer step, the crossings left and the linear offset of the first voxel; the z
// result carries last. The axis serializer feeds one axis per cycle, while the output is
// not stalled, into the shared pair of 31-stage quotient pipelines and takes the ray with
// its z axis, so new rays enter before earlier ones finish. The quotient pipeline
// freezes while a finished result is stalled; the front end freezes while its hand-off
// register holds a ray not yet taken. Register writes are applied at once and must come
// only while no ray is in flight.
module voxel_traversal_setup #(
  parameter int GRID_MAX = vts_pkg::GRID_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [vts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vts_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vts_pkg::ray_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vts_pkg::axis_out_t               out_data
);
  import vts_pkg::*;

  logic [2:0][SIZE_W-1:0]  voxel_size;
  logic [2:0][COUNT_W-1:0] grid_count;
  logic                    ray_valid;
  ray_work_t               ray;
  logic                    ray_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        voxel_size[k] <= SIZE_W'(65536);
        grid_count[k] <= COUNT_W'(128);
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOXEL_SIZE_X: voxel_size[0] <= cfg_data[SIZE_W-1:0];
        REG_VOXEL_SIZE_Y: voxel_size[1] <= cfg_data[SIZE_W-1:0];
        REG_VOXEL_SIZE_Z: voxel_size[2] <= cfg_data[SIZE_W-1:0];
        REG_GRID_COUNT_X: grid_count[0] <= cfg_data[COUNT_W-1:0];
        REG_GRID_COUNT_Y: grid_count[1] <= cfg_data[COUNT_W-1:0];
        REG_GRID_COUNT_Z: grid_count[2] <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ray-level front end: entry point, indices, numerators
  vts_ray #(
    .GRID_MAX (GRID_MAX)
  ) u_ray (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .voxel_size (voxel_size),
    .grid_count (grid_count),
    .ray_valid  (ray_valid),
    .ray        (ray),
    .ray_take   (ray_take)
  );

  // per-axis quotients and result register
  vts_axis u_axis (
    .clk       (clk),
    .rst       (rst),
    .ray_valid (ray_valid),
    .ray       (ray),
    .ray_take  (ray_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
